// File: rtl/pwq_pkg.sv
`default_nettype none

package pwq_pkg;

  localparam int unsigned MAX_WAITERS_DEF = 16;

  localparam int unsigned ID_W     = 8;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // One stored waiter: the whole word moves as a unit during a shift.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

endpackage

`default_nettype wire

// File: rtl/priority_wait_queue.sv
`default_nettype none

// Priority wait queue of thread ids: lower priority value first, equal
// priorities kept in arrival order.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. operation_i selects insert (id with priority_req_i) or
// remove (id only, from any place in the queue).
// Result channel: done_o is high for exactly one cycle per transaction with
// status, head waiter, empty flag and waiter count as they stand after the
// operation. The receiver cannot hold a result off.
// The entry memory has one read and one write port: the scan issues one read
// per cycle, then each moved entry takes a read and a write, then the head
// is read for the result.
// One transaction is in flight at a time; busy stays high until done_o.
// Rejected operations (duplicate id, full queue, absent id) leave the
// queue untouched. Reset empties the queue at once; no clearing pass.
module priority_wait_queue #(
  parameter int unsigned MAX_WAITERS = pwq_pkg::MAX_WAITERS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        operation_i,
  input  wire logic [pwq_pkg::ID_W-1:0]    thread_id_i,
  input  wire logic [pwq_pkg::PRIO_W-1:0]  priority_req_i,
  output logic                             done_o,
  output logic [pwq_pkg::STATUS_W-1:0]     status_o,
  output logic [pwq_pkg::ID_W-1:0]         head_thread_id_o,
  output logic [pwq_pkg::PRIO_W-1:0]       head_priority_o,
  output logic                             queue_empty_o,
  output logic [pwq_pkg::COUNT_W-1:0]      waiter_count_o
);
  import pwq_pkg::*;

  localparam int unsigned AddrW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_WAITERS + 1);

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  entry_t           mem_rdata;

  pwq_ctrl #(
    .MaxWaiters (MAX_WAITERS),
    .AddrW      (AddrW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .thread_id_i      (thread_id_i),
    .priority_req_i   (priority_req_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .head_thread_id_o (head_thread_id_o),
    .head_priority_o  (head_priority_o),
    .queue_empty_o    (queue_empty_o),
    .waiter_count_o   (waiter_count_o),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  pwq_mem #(
    .Depth (MAX_WAITERS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/pwq_mem.sv
`default_nettype none

module pwq_mem #(
  parameter int unsigned Depth = pwq_pkg::MAX_WAITERS_DEF,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire pwq_pkg::entry_t   wdata_i,
  input  wire logic              re_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output pwq_pkg::entry_t        rdata_o
);
  import pwq_pkg::*;

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/pwq_ctrl.sv
`default_nettype none

module pwq_ctrl #(
  parameter int unsigned MaxWaiters = pwq_pkg::MAX_WAITERS_DEF,
  parameter int unsigned AddrW      = (MaxWaiters > 1) ? $clog2(MaxWaiters) : 1,
  parameter int unsigned CntW       = $clog2(MaxWaiters + 1)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             operation_i,
  input  wire logic [pwq_pkg::ID_W-1:0]         thread_id_i,
  input  wire logic [pwq_pkg::PRIO_W-1:0]       priority_req_i,
  output logic                                  done_o,
  output logic [pwq_pkg::STATUS_W-1:0]          status_o,
  output logic [pwq_pkg::ID_W-1:0]              head_thread_id_o,
  output logic [pwq_pkg::PRIO_W-1:0]            head_priority_o,
  output logic                                  queue_empty_o,
  output logic [pwq_pkg::COUNT_W-1:0]           waiter_count_o,
  // memory port
  output logic                                  mem_we_o,
  output logic [AddrW-1:0]                      mem_waddr_o,
  output pwq_pkg::entry_t                       mem_wdata_o,
  output logic                                  mem_re_o,
  output logic [AddrW-1:0]                      mem_raddr_o,
  input  wire pwq_pkg::entry_t                  mem_rdata_i
);
  import pwq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_SHIFT_RD = 3'd2;
  localparam logic [2:0] S_SHIFT_WR = 3'd3;
  localparam logic [2:0] S_PUT      = 3'd4;
  localparam logic [2:0] S_HEAD     = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  localparam logic [CntW-1:0] CntMax = CntW'(MaxWaiters);

  logic [2:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic [CntW-1:0]   chk_q, chk_d;
  logic [CntW-1:0]   tgt_q, tgt_d;
  logic [CntW-1:0]   fpos_q, fpos_d;
  logic [CntW-1:0]   ipos_q, ipos_d;
  logic              rvld_q, rvld_d;
  logic              found_q, found_d;
  logic              ipos_set_q, ipos_set_d;
  logic              done_q, done_d;

  op_e               op_q, op_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  status_e           status_q, status_d;
  logic [ID_W-1:0]   hid_q, hid_d;
  logic [PRIO_W-1:0] hprio_q, hprio_d;
  logic              empty_q, empty_d;

  logic scan_done;

  assign scan_done = (ptr_q == cnt_q) && !rvld_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;
    chk_d      = chk_q;
    tgt_d      = tgt_q;
    fpos_d     = fpos_q;
    ipos_d     = ipos_q;
    rvld_d     = 1'b0;
    found_d    = found_q;
    ipos_set_d = ipos_set_q;
    done_d     = 1'b0;
    op_d       = op_q;
    id_d       = id_q;
    prio_d     = prio_q;
    status_d   = status_q;
    hid_d      = hid_q;
    hprio_d    = hprio_q;
    empty_d    = empty_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q[AddrW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q[AddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d       = op_e'(operation_i);
          id_d       = thread_id_i;
          prio_d     = priority_req_i;
          ptr_d      = '0;
          found_d    = 1'b0;
          ipos_set_d = 1'b0;
          state_d    = S_SCAN;
        end
      end

      S_SCAN: begin
        // issue one read a cycle, check the word that returned
        if (ptr_q < cnt_q) begin
          mem_re_o = 1'b1;
          rvld_d   = 1'b1;
          chk_d    = ptr_q;
          ptr_d    = ptr_q + 1'b1;
        end
        if (rvld_q) begin
          if (!found_q && (mem_rdata_i.id == id_q)) begin
            found_d = 1'b1;
            fpos_d  = chk_q;
          end
          if (!ipos_set_q && (mem_rdata_i.prio > prio_q)) begin
            ipos_set_d = 1'b1;
            ipos_d     = chk_q;
          end
        end
        if (scan_done) begin
          if (op_q == OP_INSERT) begin
            if (found_q) begin
              status_d = ST_DUPLICATE;
              state_d  = S_HEAD;
            end else if (cnt_q == CntMax) begin
              status_d = ST_FULL;
              state_d  = S_HEAD;
            end else begin
              tgt_d   = ipos_set_q ? ipos_q : cnt_q;
              ptr_d   = cnt_q;
              state_d = S_SHIFT_RD;
            end
          end else begin
            if (!found_q) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_HEAD;
            end else begin
              tgt_d   = cnt_q - 1'b1;
              ptr_d   = fpos_q;
              state_d = S_SHIFT_RD;
            end
          end
        end
      end

      S_SHIFT_RD: begin
        // ptr_q is the destination of the next move
        if (ptr_q == tgt_q) begin
          if (op_q == OP_INSERT) begin
            state_d = S_PUT;
          end else begin
            cnt_d    = cnt_q - 1'b1;
            status_d = ST_OK;
            state_d  = S_HEAD;
          end
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = (op_q == OP_INSERT) ? AddrW'(ptr_q - 1'b1) : AddrW'(ptr_q + 1'b1);
          state_d     = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q[AddrW-1:0];
        mem_wdata_o = mem_rdata_i;
        ptr_d       = (op_q == OP_INSERT) ? ptr_q - 1'b1 : ptr_q + 1'b1;
        state_d     = S_SHIFT_RD;
      end

      S_PUT: begin
        mem_we_o         = 1'b1;
        mem_waddr_o      = tgt_q[AddrW-1:0];
        mem_wdata_o.id   = id_q;
        mem_wdata_o.prio = prio_q;
        cnt_d            = cnt_q + 1'b1;
        status_d         = ST_OK;
        state_d          = S_HEAD;
      end

      S_HEAD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = '0;
        state_d     = S_RESP;
      end

      S_RESP: begin
        empty_d = (cnt_q == '0);
        hid_d   = (cnt_q == '0) ? '0 : mem_rdata_i.id;
        hprio_d = (cnt_q == '0) ? '0 : mem_rdata_i.prio;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      ptr_q      <= '0;
      rvld_q     <= 1'b0;
      found_q    <= 1'b0;
      ipos_set_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ptr_q      <= ptr_d;
      rvld_q     <= rvld_d;
      found_q    <= found_d;
      ipos_set_q <= ipos_set_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q    <= chk_d;
    tgt_q    <= tgt_d;
    fpos_q   <= fpos_d;
    ipos_q   <= ipos_d;
    op_q     <= op_d;
    id_q     <= id_d;
    prio_q   <= prio_d;
    status_q <= status_d;
    hid_q    <= hid_d;
    hprio_q  <= hprio_d;
    empty_q  <= empty_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign head_thread_id_o = hid_q;
  assign head_priority_o  = hprio_q;
  assign queue_empty_o    = empty_q;
  assign waiter_count_o   = COUNT_W'(cnt_q);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("waiter count beyond capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> (cnt_q == CntW'($past(cnt_q) + 1'b1)) ||
                        (cnt_q == CntW'($past(cnt_q) - 1'b1)))
    else $error("waiter count moved by more than one");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == S_SHIFT_WR) || (state_q == S_PUT))
    else $error("memory write outside shift or put");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (empty_q == (cnt_q == '0)))
    else $error("empty flag disagrees with count");

  a_error_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q != ST_OK)) |-> $stable(cnt_q))
    else $error("count changed on a rejected transaction");

endmodule

`default_nettype wire

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwq_pkg::*;

  localparam int unsigned DEPTH       = MAX_WAITERS_DEF;
  localparam int unsigned DIR_ROWS    = 25;
  localparam int unsigned TOTAL_ITEMS = 950;
  localparam int unsigned PRESSURE_AT = 250;
  localparam int unsigned QUIET_FROM  = 400;
  localparam int unsigned QUIET_TO    = 600;
  localparam int unsigned TAIL_CYCLES = 3 * DEPTH + 6;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_CAP   = 40;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   head_id;
    logic [PRIO_W-1:0] head_prio;
    logic              empty;
    logic [COUNT_W-1:0] count;
  } wait_result_t;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   tid;
    logic [PRIO_W-1:0] tprio;
    logic              typed;
    wait_result_t      want;
  } dir_row_t;

  localparam wait_result_t NO_CHECK = '{ST_OK, 8'h00, 8'h00, 1'b0, 5'd0};

  // Typed rows carry the result as read off the queue contents by hand.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_REMOVE, 8'h07, 8'h00, 1'b1, '{ST_NOT_FOUND, 8'h00, 8'h00, 1'b1, 5'd0}},
    '{OP_INSERT, 8'h00, 8'hFF, 1'b1, '{ST_OK,        8'h00, 8'hFF, 1'b0, 5'd1}},
    '{OP_INSERT, 8'hFF, 8'h00, 1'b1, '{ST_OK,        8'hFF, 8'h00, 1'b0, 5'd2}},
    '{OP_INSERT, 8'hFF, 8'h09, 1'b1, '{ST_DUPLICATE, 8'hFF, 8'h00, 1'b0, 5'd2}},
    '{OP_INSERT, 8'h12, 8'h00, 1'b1, '{ST_OK,        8'hFF, 8'h00, 1'b0, 5'd3}},
    '{OP_REMOVE, 8'hFF, 8'hAA, 1'b1, '{ST_OK,        8'h12, 8'h00, 1'b0, 5'd2}},
    '{OP_REMOVE, 8'hFF, 8'h00, 1'b1, '{ST_NOT_FOUND, 8'h12, 8'h00, 1'b0, 5'd2}},
    '{OP_INSERT, 8'hA0, 8'h80, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'hA1, 8'h00, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'hA2, 8'hFF, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'hA3, 8'h40, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'hA4, 8'h00, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'hA5, 8'h7F, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'hA6, 8'h01, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'hA7, 8'hFE, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'hA8, 8'h40, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'hA9, 8'h10, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'hAA, 8'h00, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'hAB, 8'hC3, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'hAC, 8'h3C, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'hAD, 8'h55, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'h55, 8'h01, 1'b0, NO_CHECK},
    '{OP_INSERT, 8'h00, 8'h20, 1'b0, NO_CHECK},
    '{OP_REMOVE, 8'h00, 8'h00, 1'b0, NO_CHECK},
    '{OP_REMOVE, 8'h12, 8'h00, 1'b0, NO_CHECK}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  op_e                operation_i;
  logic [ID_W-1:0]    thread_id_i;
  logic [PRIO_W-1:0]  priority_req_i;
  logic               done_o;
  logic [STATUS_W-1:0] status_o;
  logic [ID_W-1:0]    head_thread_id_o;
  logic [PRIO_W-1:0]  head_priority_o;
  logic               queue_empty_o;
  logic [COUNT_W-1:0] waiter_count_o;

  entry_t       waiters [$];
  wait_result_t pending_results [$];
  int unsigned  mismatches;
  int unsigned  sent;
  int unsigned  received;
  int unsigned  cycles;
  int unsigned  status_seen [4];
  int unsigned  empty_seen;

  priority_wait_queue DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .thread_id_i      (thread_id_i),
    .priority_req_i   (priority_req_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .head_thread_id_o (head_thread_id_o),
    .head_priority_o  (head_priority_o),
    .queue_empty_o    (queue_empty_o),
    .waiter_count_o   (waiter_count_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Apply one operation to the shadow queue and return what the block reports.
  function automatic wait_result_t apply_wait_op(input op_e op, input logic [ID_W-1:0] tid,
                                                 input logic [PRIO_W-1:0] tprio);
    wait_result_t r;
    int           found;
    int           pos;
    found = -1;
    foreach (waiters[i]) begin
      if (found < 0 && waiters[i].id == tid) found = i;
    end
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (found >= 0) begin
        r.status = ST_DUPLICATE;
      end else if (waiters.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // go behind every waiter of equal or better priority
        pos = 0;
        while (pos < waiters.size() && waiters[pos].prio <= tprio) pos++;
        waiters.insert(pos, '{id: tid, prio: tprio});
      end
    end else if (found < 0) begin
      r.status = ST_NOT_FOUND;
    end else begin
      waiters.delete(found);
    end
    if (waiters.size() > 0) begin
      r.head_id   = waiters[0].id;
      r.head_prio = waiters[0].prio;
      r.empty     = 1'b0;
    end else begin
      r.head_id   = '0;
      r.head_prio = '0;
      r.empty     = 1'b1;
    end
    r.count = COUNT_W'(waiters.size());
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] result %0d: %s", $realtime, received, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  // Present one command and hold it until the block takes it.
  task automatic issue(input op_e op, input logic [ID_W-1:0] tid,
                       input logic [PRIO_W-1:0] tprio, input logic typed,
                       input wait_result_t want);
    wait_result_t pred;
    start          <= 1'b1;
    operation_i    <= op;
    thread_id_i    <= tid;
    priority_req_i <= tprio;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    pred = apply_wait_op(op, tid, tprio);
    pending_results.push_back(typed ? want : pred);
    sent++;
  endtask

  task automatic sender_gap();
    if (sent == PRESSURE_AT) begin
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
    end else if ((sent < QUIET_FROM || sent >= QUIET_TO) && $urandom_range(99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(60, 1)) @(posedge clk_i);
    end
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    // a small pool keeps duplicates and hits frequent
    if ($urandom_range(99) < 80) return ID_W'($urandom_range(23));
    return ID_W'($urandom_range(255));
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    wait_result_t exp_r;
    if (rst_ni && done_o === 1'b1) begin
      received++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", 8'(status_o), 8'(exp_r.status));
        check_field("head_thread_id", head_thread_id_o, exp_r.head_id);
        check_field("head_priority", head_priority_o, exp_r.head_prio);
        check_field("queue_empty", 8'(queue_empty_o), 8'(exp_r.empty));
        check_field("waiter_count", 8'(waiter_count_o), 8'(exp_r.count));
        status_seen[exp_r.status]++;
        if (exp_r.empty) empty_seen++;
      end
    end
  end

  initial begin
    op_e              op;
    logic [ID_W-1:0]  tid;
    logic [PRIO_W-1:0] tprio;
    int unsigned      insert_pct;
    rst_ni         = 1'b0;
    start          = 1'b0;
    operation_i    = OP_INSERT;
    thread_id_i    = '0;
    priority_req_i = '0;
    mismatches     = 0;
    sent           = 0;
    received       = 0;
    cycles         = 0;
    empty_seen     = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      issue(DIRECTED[r].op, DIRECTED[r].tid, DIRECTED[r].tprio, DIRECTED[r].typed,
            DIRECTED[r].want);
      sender_gap();
    end

    while (sent < TOTAL_ITEMS) begin
      // alternate filling and draining so both full and empty are reached
      insert_pct = ((sent / 60) % 2 == 0) ? 70 : 35;
      tprio = ($urandom_range(1) == 0) ? PRIO_W'($urandom_range(7))
                                       : PRIO_W'($urandom_range(255));
      if ($urandom_range(99) < insert_pct) begin
        op  = OP_INSERT;
        tid = pick_id();
      end else begin
        op = OP_REMOVE;
        if (waiters.size() > 0 && $urandom_range(99) < 75)
          tid = waiters[$urandom_range(waiters.size() - 1)].id;
        else
          tid = pick_id();
      end
      issue(op, tid, tprio, 1'b0, NO_CHECK);
      if (sent < TOTAL_ITEMS) sender_gap();
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d transactions: %0d ok, %0d full, %0d not found, %0d duplicate",
             received, status_seen[ST_OK], status_seen[ST_FULL],
             status_seen[ST_NOT_FOUND], status_seen[ST_DUPLICATE]);
    $display("%0d results left the queue empty, %0d mismatches", empty_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
